@@ rtl/wis_pkg.sv @@
// ----------------------------------------------------------------------------
// wis_pkg
// Shared types and constants for the weighted interval selection block.
// ----------------------------------------------------------------------------
package wis_pkg;

    localparam int DEF_MAX_INTERVALS = 1024;
    localparam int DEF_POS_BITS      = 17;
    localparam int DEF_VALUE_BITS    = 10;
    localparam int TOTAL_BITS        = 20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_CMP_I,
        ST_I_LATCH,
        ST_J_TEST,
        ST_J_CMP,
        ST_STORE
    } t_state;

    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_shift;
        logic ins_write;
        logic cmp_init;
        logic i_rd;
        logic i_latch;
        logic j_rd;
        logic j_acc;
        logic i_store;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic pos_zero;
        logic shift_needed;
        logic i_done;
        logic j_done;
    } t_stat;

endpackage

@@ rtl/wis_datapath.sv @@
// ----------------------------------------------------------------------------
// wis_datapath
// Interval store, insertion shifter and chain evaluation datapath.
// ----------------------------------------------------------------------------
module wis_datapath #(
    parameter int MAX_INTERVALS = wis_pkg::DEF_MAX_INTERVALS,
    parameter int POS_BITS      = wis_pkg::DEF_POS_BITS,
    parameter int VALUE_BITS    = wis_pkg::DEF_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wis_pkg::t_cmd                     i_cmd,
    output wis_pkg::t_stat                    o_stat,
    input  logic [POS_BITS-1:0]               i_start_req,
    input  logic [POS_BITS-1:0]               i_length,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic                              i_last,
    output logic                              o_valid,
    output logic [wis_pkg::TOTAL_BITS-1:0]    o_best_total
);

    localparam int AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW    = $clog2(MAX_INTERVALS + 1);
    localparam int EW    = POS_BITS + 1;
    localparam int WW    = POS_BITS + EW + VALUE_BITS;
    localparam int TW    = wis_pkg::TOTAL_BITS;
    localparam int SW    = ((VALUE_BITS > TW) ? VALUE_BITS : TW) + 1;
    localparam logic [SW-1:0] SAT = SW'({TW{1'b1}});

    logic [WW-1:0] mem_entry [MAX_INTERVALS];
    logic [TW-1:0] mem_chain [MAX_INTERVALS];

    logic [WW-1:0]         r_rd_q;
    logic [TW-1:0]         r_chain_q;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [POS_BITS-1:0]   r_s;
    logic [EW-1:0]         r_e;
    logic [VALUE_BITS-1:0] r_v;
    logic                  r_last;
    logic [POS_BITS-1:0]   r_si;
    logic [VALUE_BITS-1:0] r_vi;
    logic [TW-1:0]         r_best;
    logic [TW-1:0]         r_overall;
    logic                  r_valid;
    logic [TW-1:0]         r_out;

    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic [CW-1:0]         pos_m1;
    logic [POS_BITS-1:0]   q_start;
    logic [EW-1:0]         q_end;
    logic [VALUE_BITS-1:0] q_value;
    logic [POS_BITS-1:0]   len_fix;
    logic [SW-1:0]         sum;
    logic [TW-1:0]         total;

    assign pos_m1  = r_pos - CW'(1);
    assign q_start = r_rd_q[WW-1 -: POS_BITS];
    assign q_end   = r_rd_q[VALUE_BITS +: EW];
    assign q_value = r_rd_q[VALUE_BITS-1:0];
    assign len_fix = (i_length == '0) ? POS_BITS'(1) : i_length;
    assign sum     = SW'(r_best) + SW'(r_vi);
    assign total   = (sum > SAT) ? TW'(SAT) : sum[TW-1:0];

    always_comb begin
        rd_en   = i_cmd.ins_rd | i_cmd.i_rd | i_cmd.j_rd;
        rd_addr = r_j[AW-1:0];
        if (i_cmd.ins_rd) begin
            rd_addr = pos_m1[AW-1:0];
        end else if (i_cmd.i_rd) begin
            rd_addr = r_i[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_shift) begin
            mem_entry[r_pos[AW-1:0]] <= r_rd_q;
        end else if (i_cmd.ins_write) begin
            mem_entry[r_pos[AW-1:0]] <= {r_s, r_e, r_v};
        end
        if (rd_en) begin
            r_rd_q <= mem_entry[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.i_store) begin
            mem_chain[r_i[AW-1:0]] <= total;
        end
        if (i_cmd.j_rd) begin
            r_chain_q <= mem_chain[r_j[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s    <= i_start_req;
            r_e    <= EW'(i_start_req) + EW'(len_fix) - EW'(1);
            r_v    <= i_value;
            r_last <= i_last;
        end
        if (i_cmd.i_latch) begin
            r_si <= q_start;
            r_vi <= q_value;
        end
        if (i_cmd.i_rd) begin
            r_best <= '0;
        end else if (i_cmd.j_acc) begin
            if ((EW'(r_si) > q_end) && (r_chain_q > r_best)) begin
                r_best <= r_chain_q;
            end
        end
        if (i_cmd.finish) begin
            r_out <= r_overall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pos     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_overall <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_pos <= r_count;
            end else if (i_cmd.ins_shift) begin
                r_pos <= pos_m1;
            end
            if (i_cmd.finish) begin
                r_count <= '0;
            end else if (i_cmd.ins_write) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.cmp_init) begin
                r_i       <= '0;
                r_overall <= '0;
            end else if (i_cmd.i_store) begin
                r_i <= r_i + CW'(1);
                if (total > r_overall) begin
                    r_overall <= total;
                end
            end
            if (i_cmd.i_rd) begin
                r_j <= '0;
            end else if (i_cmd.j_acc) begin
                r_j <= r_j + CW'(1);
            end
        end
    end

    always_comb begin
        o_stat.full         = (r_count == CW'(MAX_INTERVALS));
        o_stat.last         = r_last;
        o_stat.pos_zero     = (r_pos == '0);
        o_stat.shift_needed = (q_start > r_s);
        o_stat.i_done       = (r_i == r_count);
        o_stat.j_done       = (r_j == r_i);
    end

    assign o_valid      = r_valid;
    assign o_best_total = r_out;

endmodule

@@ rtl/wis_ctrl.sv @@
// ----------------------------------------------------------------------------
// wis_ctrl
// Sequencer for sorted insertion and the quadratic chain evaluation.
// ----------------------------------------------------------------------------
module wis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_last,
    input  wis_pkg::t_stat i_stat,
    output wis_pkg::t_cmd  o_cmd
);

    wis_pkg::t_state r_state;
    wis_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            wis_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.full) begin
                        n_state = wis_pkg::ST_INS_CHK;
                    end else if (i_last) begin
                        o_cmd.cmp_init = 1'b1;
                        n_state        = wis_pkg::ST_CMP_I;
                    end
                end
            end
            wis_pkg::ST_INS_CHK: begin
                if (i_stat.pos_zero) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.cmp_init  = i_stat.last;
                    n_state = i_stat.last ? wis_pkg::ST_CMP_I : wis_pkg::ST_IDLE;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = wis_pkg::ST_INS_CMP;
                end
            end
            wis_pkg::ST_INS_CMP: begin
                if (i_stat.shift_needed) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = wis_pkg::ST_INS_CHK;
                end else begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.cmp_init  = i_stat.last;
                    n_state = i_stat.last ? wis_pkg::ST_CMP_I : wis_pkg::ST_IDLE;
                end
            end
            wis_pkg::ST_CMP_I: begin
                if (i_stat.i_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = wis_pkg::ST_IDLE;
                end else begin
                    o_cmd.i_rd = 1'b1;
                    n_state    = wis_pkg::ST_I_LATCH;
                end
            end
            wis_pkg::ST_I_LATCH: begin
                o_cmd.i_latch = 1'b1;
                n_state       = wis_pkg::ST_J_TEST;
            end
            wis_pkg::ST_J_TEST: begin
                if (i_stat.j_done) begin
                    n_state = wis_pkg::ST_STORE;
                end else begin
                    o_cmd.j_rd = 1'b1;
                    n_state    = wis_pkg::ST_J_CMP;
                end
            end
            wis_pkg::ST_J_CMP: begin
                o_cmd.j_acc = 1'b1;
                n_state     = wis_pkg::ST_J_TEST;
            end
            wis_pkg::ST_STORE: begin
                o_cmd.i_store = 1'b1;
                n_state       = wis_pkg::ST_CMP_I;
            end
            default: begin
                n_state = wis_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != wis_pkg::ST_IDLE);

endmodule

@@ rtl/weighted_interval_select.sv @@
// ----------------------------------------------------------------------------
// weighted_interval_select
// Weighted interval scheduling: loads intervals and reports the best total.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each transaction
// carries one interval and a last mark. The interval is inserted in order of
// start by shifting larger stored entries up one slot; each shifted entry is
// read, then written one slot higher. Intervals beyond MAX_INTERVALS are
// dropped, but their last mark still counts.
// On a last transaction the block evaluates every stored interval against all
// earlier ones through a single read port of the interval memory, and then
// pulses o_valid for one cycle with o_best_total. Busy stays high for the
// whole load and evaluation.
// The receiver cannot stall, so the result is presented exactly once.
// Reset empties the set and returns the sequencer to idle; the memories are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module weighted_interval_select #(
    parameter int MAX_INTERVALS = wis_pkg::DEF_MAX_INTERVALS,
    parameter int POS_BITS      = wis_pkg::DEF_POS_BITS,
    parameter int VALUE_BITS    = wis_pkg::DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [POS_BITS-1:0]            i_start_req,
    input  logic [POS_BITS-1:0]            i_length,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  logic                           i_last,
    output logic                           o_valid,
    output logic [wis_pkg::TOTAL_BITS-1:0] o_best_total
);

    wis_pkg::t_cmd  cmd;
    wis_pkg::t_stat stat;

    wis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wis_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .POS_BITS      (POS_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_start_req  (i_start_req),
        .i_length     (i_length),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .o_best_total (o_best_total)
    );

endmodule

@@ tb/tb_weighted_interval_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_interval_select
// Drives interval sets into the block and checks each reported best total
// against an in-bench dynamic-programming predictor of the selection.
// ----------------------------------------------------------------------------
module tb_weighted_interval_select;

    localparam int  NSLOTS     = wis_pkg::DEF_MAX_INTERVALS;
    localparam int  PBITS      = wis_pkg::DEF_POS_BITS;
    localparam int  VBITS      = wis_pkg::DEF_VALUE_BITS;
    localparam int  TBITS      = wis_pkg::TOTAL_BITS;
    localparam int  TOTAL_CAP  = (1 << TBITS) - 1;
    localparam int  POS_TOP    = (1 << PBITS) - 1;
    localparam int  VAL_TOP    = (1 << VBITS) - 1;
    localparam longint CYCLE_LIMIT = 400000;

    class best_total_board;
        int unsigned iv_start[NSLOTS];
        int unsigned iv_end[NSLOTS];
        int unsigned iv_value[NSLOTS];
        int unsigned chain_total[NSLOTS];
        int unsigned stored;
        int unsigned pending_totals[$];
        int unsigned errors;

        function new();
            stored = 0;
            errors = 0;
        endfunction

        function void note_interval(bit [PBITS-1:0] s, bit [PBITS-1:0] len,
                                    bit [VBITS-1:0] v, bit last);
            int unsigned span;
            int unsigned pos;
            int unsigned best;
            int unsigned sum;
            int unsigned top;
            span = (len == 0) ? 1 : len;
            if (stored < NSLOTS) begin
                pos = stored;
                while (pos > 0 && iv_start[pos-1] > s) begin
                    iv_start[pos] = iv_start[pos-1];
                    iv_end[pos]   = iv_end[pos-1];
                    iv_value[pos] = iv_value[pos-1];
                    pos--;
                end
                iv_start[pos] = s;
                iv_end[pos]   = s + span - 1;
                iv_value[pos] = v;
                stored++;
            end
            if (last) begin
                top = 0;
                for (int i = 0; i < stored; i++) begin
                    best = 0;
                    for (int j = 0; j < i; j++)
                        if (iv_start[i] > iv_end[j] && chain_total[j] > best)
                            best = chain_total[j];
                    sum = best + iv_value[i];
                    if (sum > TOTAL_CAP) sum = TOTAL_CAP;
                    chain_total[i] = sum;
                    if (sum > top) top = sum;
                end
                pending_totals.push_back(top);
                stored = 0;
            end
        endfunction

        function void check_total(bit [TBITS-1:0] actual);
            int unsigned want;
            if (pending_totals.size() == 0) begin
                $error("best_total: unexpected result %0d", actual);
                errors++;
            end else begin
                want = pending_totals.pop_front();
                if (actual != want) begin
                    $error("best_total: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [PBITS-1:0]      i_start_req = '0;
    logic [PBITS-1:0]      i_length = '0;
    logic [VBITS-1:0]      i_value = '0;
    logic                  i_last = 1'b0;
    logic                  o_valid;
    logic [TBITS-1:0]      o_best_total;

    best_total_board board = new();
    int     idle_pct;
    longint cycles = 0;

    weighted_interval_select dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_start_req  (i_start_req),
        .i_length     (i_length),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .o_best_total (o_best_total)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_total(o_best_total);
    end

    task automatic send_interval(int unsigned s, int unsigned len, int unsigned v, bit last);
        start       <= 1'b1;
        i_start_req <= s[PBITS-1:0];
        i_length    <= len[PBITS-1:0];
        i_value     <= v[VBITS-1:0];
        i_last      <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_interval(s[PBITS-1:0], len[PBITS-1:0], v[VBITS-1:0], last);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_set(int unsigned count);
        bit wide;
        for (int k = 0; k < count; k++) begin
            wide = ($urandom_range(3) == 0);
            if (wide)
                send_interval($urandom_range(POS_TOP), $urandom_range(POS_TOP),
                              $urandom_range(VAL_TOP), k == count - 1);
            else
                send_interval($urandom_range(63), $urandom_range(12),
                              $urandom_range(VAL_TOP), k == count - 1);
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned count;
        idle_pct = 13;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_interval(POS_TOP, POS_TOP, VAL_TOP, 1'b1);
        send_interval(0, 0, 0, 1'b1);
        send_interval(5, 0, 7, 1'b0);
        send_interval(5, 1, 9, 1'b0);
        send_interval(6, 3, 11, 1'b0);
        send_interval(8, 2, 13, 1'b0);
        send_interval(9, POS_TOP, VAL_TOP, 1'b1);
        send_interval(40, 10, 100, 1'b0);
        send_interval(10, 10, 200, 1'b0);
        send_interval(20, 20, 300, 1'b0);
        send_interval(0, 10, 50, 1'b0);
        send_interval(20, 5, 60, 1'b1);
        send_interval(3, 1, VAL_TOP, 1'b0);
        send_interval(3, 1, 1, 1'b0);
        send_interval(3, 1, 2, 1'b1);

        sent = 0;
        while (sent < 560) begin
            if (sent < 190) idle_pct = 13;
            else if (sent < 380) idle_pct = 47;
            else idle_pct = 0;
            count = ($urandom_range(19) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            send_random_set(count);
            sent += count;
        end

        send_random_set(3);

        start <= 1'b0;
        while (board.pending_totals.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/wis_pkg.sv
rtl/wis_datapath.sv
rtl/wis_ctrl.sv
rtl/weighted_interval_select.sv
tb/tb_weighted_interval_select.sv
